// ===== rtl/core/load_store_address_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Load/store address generator assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_ADDRESS_GENERATOR_DEFINES_SVH
`define LOAD_STORE_ADDRESS_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check an implication within the same clock edge
`define LSAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication at the following clock edge
`define LSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lsag_pkg.sv =====
// ----------------------------------------------------------------------------
// Load/store address generator package
// Codes, stage payload types and constants shared by the pipeline stages.
// ----------------------------------------------------------------------------
package lsag_pkg;

  localparam int IN_W  = 104;
  localparam int OUT_W = 112;

  localparam logic [31:0] MULTI_STEP = 32'd4;
  localparam logic [3:0]  RD_LR      = 4'd14;

  typedef enum logic [3:0] {
    CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
    CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
  } cond_t;

  typedef enum logic [2:0] {
    CLS_MISC, CLS_DP_IMM, CLS_IMM, CLS_REG,
    CLS_MULTI, CLS_BRANCH, CLS_COPROC, CLS_SWI
  } class_t;

  typedef enum logic [1:0] {
    K_SINGLE, K_MULTI, K_UNDEF
  } kind_t;

  typedef enum logic [1:0] {
    SH_LSL, SH_LSR, SH_ASR, SH_ROR
  } shift_t;

  typedef enum logic [2:0] {
    SZ_WORD, SZ_BYTE, SZ_HALF, SZ_DWORD, SZ_MULTI
  } size_t;

  typedef enum logic [1:0] {
    ST_OK, ST_UNDEF, ST_UNPRED
  } status_t;

  // Decode stage payload
  typedef struct packed {
    logic        pass;
    kind_t       kind;
    logic        p;
    logic        u;
    logic        w;
    size_t       size;
    logic        load;
    logic [4:0]  cnt;
    logic        dword;
    logic        rd_bad;
    logic        use_imm;
    logic [11:0] imm;
    logic [4:0]  amt;
    shift_t      stype;
    logic        carry;
    logic [31:0] rn;
    logic [31:0] rm;
  } dec_t;

  // Offset stage payload: signed offsets added to the base in the last stage
  typedef struct packed {
    logic        pass;
    logic        undef;
    logic        wb_pre;
    size_t       size;
    logic        load;
    logic [4:0]  cnt;
    logic        dword;
    logic        rd_bad;
    logic [31:0] rn;
    logic [31:0] a_off;
    logic [31:0] nb_off;
    logic [31:0] e_off;
  } off_t;

  // Result payload
  typedef struct packed {
    status_t     status;
    logic [4:0]  cnt;
    logic        load;
    size_t       size;
    logic        wb;
    logic [31:0] nb;
    logic [31:0] end_addr;
    logic [31:0] addr;
    logic        pass;
  } res_t;

endpackage

// ===== rtl/core/lsag_decode.sv =====
// ----------------------------------------------------------------------------
// Load/store address generator decode stage
// Evaluates the condition, classifies the encoding and counts the register
// list, then registers the decoded transaction.
// ----------------------------------------------------------------------------
module lsag_decode
  import lsag_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_in,
  output logic        ready_in,
  input  logic [31:0] instruction,
  input  logic [31:0] base_value,
  input  logic [31:0] offset_value,
  input  logic [3:0]  nzcv_flags,
  output logic        valid_r,
  input  logic        ready_out,
  output dec_t        dec_r
);

  dec_t       dec_nxt;
  logic       pass;
  logic [4:0] pop;
  logic       fn, fz, fc, fv;

  assign fn = nzcv_flags[3];
  assign fz = nzcv_flags[2];
  assign fc = nzcv_flags[1];
  assign fv = nzcv_flags[0];

  // Count set bits of a nibble
  function automatic logic [2:0] pop4(input logic [3:0] x);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 0; i < 4; i++) begin
      k = k + 3'(x[i]);
    end
    return k;
  endfunction

  // Count the register list as four nibble counts
  assign pop = 5'(pop4(instruction[3:0])) + 5'(pop4(instruction[7:4]))
             + 5'(pop4(instruction[11:8])) + 5'(pop4(instruction[15:12]));

  // Evaluate the condition field
  always_comb begin
    unique case (cond_t'(instruction[31:28]))
      CC_EQ:   pass = fz;
      CC_NE:   pass = !fz;
      CC_CS:   pass = fc;
      CC_CC:   pass = !fc;
      CC_MI:   pass = fn;
      CC_PL:   pass = !fn;
      CC_VS:   pass = fv;
      CC_VC:   pass = !fv;
      CC_HI:   pass = fc && !fz;
      CC_LS:   pass = !fc || fz;
      CC_GE:   pass = (fn == fv);
      CC_LT:   pass = (fn != fv);
      CC_GT:   pass = !fz && (fn == fv);
      CC_LE:   pass = fz || (fn != fv);
      CC_AL:   pass = 1'b1;
      default: pass = 1'b0;
    endcase
  end

  // Classify the encoding
  always_comb begin
    dec_nxt         = '0;
    dec_nxt.pass    = pass;
    dec_nxt.kind    = K_UNDEF;
    dec_nxt.p       = instruction[24];
    dec_nxt.u       = instruction[23];
    dec_nxt.w       = instruction[21];
    dec_nxt.size    = SZ_WORD;
    dec_nxt.load    = instruction[20];
    dec_nxt.cnt     = 5'd0;
    dec_nxt.rd_bad  = instruction[12] || (instruction[15:12] == RD_LR);
    dec_nxt.use_imm = 1'b1;
    dec_nxt.stype   = SH_LSL;
    dec_nxt.carry   = fc;
    dec_nxt.rn      = base_value;
    dec_nxt.rm      = offset_value;
    unique case (class_t'(instruction[27:25]))
      CLS_IMM: begin
        dec_nxt.kind = K_SINGLE;
        dec_nxt.imm  = instruction[11:0];
        dec_nxt.size = instruction[22] ? SZ_BYTE : SZ_WORD;
        dec_nxt.cnt  = 5'd1;
      end
      CLS_REG: begin
        if (!instruction[4]) begin
          dec_nxt.kind    = K_SINGLE;
          dec_nxt.use_imm = 1'b0;
          dec_nxt.amt     = instruction[11:7];
          dec_nxt.stype   = shift_t'(instruction[6:5]);
          dec_nxt.size    = instruction[22] ? SZ_BYTE : SZ_WORD;
          dec_nxt.cnt     = 5'd1;
        end
      end
      CLS_MISC: begin
        if (instruction[7] && instruction[4] && (instruction[6:5] != 2'd0)) begin
          dec_nxt.kind    = K_SINGLE;
          dec_nxt.use_imm = instruction[22];
          dec_nxt.imm     = {4'd0, instruction[11:8], instruction[3:0]};
          dec_nxt.cnt     = 5'd1;
          if (instruction[20]) begin
            dec_nxt.size = (instruction[6:5] == 2'd2) ? SZ_BYTE : SZ_HALF;
          end else if (instruction[6:5] == 2'd1) begin
            dec_nxt.size = SZ_HALF;
          end else begin
            // Doubleword: signed-byte slot loads, signed-halfword slot stores
            dec_nxt.size  = SZ_DWORD;
            dec_nxt.cnt   = 5'd2;
            dec_nxt.load  = (instruction[6:5] == 2'd2);
            dec_nxt.dword = 1'b1;
          end
        end
      end
      CLS_MULTI: begin
        dec_nxt.kind = K_MULTI;
        dec_nxt.size = SZ_MULTI;
        dec_nxt.cnt  = pop;
      end
      default: begin
        dec_nxt.kind = K_UNDEF;
      end
    endcase
  end

  // Advance when the register is empty or its transaction moves on
  assign ready_in = !valid_r || ready_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

// ===== rtl/core/lsag_offset.sv =====
// ----------------------------------------------------------------------------
// Load/store address generator offset stage
// Applies the scaled register shift and turns the indexing mode into three
// signed offsets from the base: access, end and new base.
// ----------------------------------------------------------------------------
module lsag_offset
  import lsag_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic valid_in,
  output logic ready_in,
  input  dec_t dec,
  output logic valid_r,
  input  logic ready_out,
  output off_t off_r
);

  off_t        off_nxt;
  logic [31:0] scaled;
  logic [63:0] rot;
  logic [31:0] offset;
  logic [31:0] moved;
  logic [31:0] bytes;
  logic [31:0] nbytes;

  assign rot = {dec.rm, dec.rm} >> dec.amt;

  // Shift the offset register
  always_comb begin
    case (dec.stype)
      SH_LSL:  scaled = dec.rm << dec.amt;
      SH_LSR:  scaled = (dec.amt == 5'd0) ? 32'd0 : (dec.rm >> dec.amt);
      SH_ASR:  scaled = (dec.amt == 5'd0) ? {32{dec.rm[31]}}
                                          : 32'($signed(dec.rm) >>> dec.amt);
      default: scaled = (dec.amt == 5'd0) ? {dec.carry, dec.rm[31:1]} : rot[31:0];
    endcase
  end

  assign offset = dec.use_imm ? {20'd0, dec.imm} : scaled;
  assign moved  = dec.u ? offset : (~offset + 32'd1);
  assign bytes  = {25'd0, dec.cnt, 2'b00};
  assign nbytes = ~bytes + 32'd1;

  // Build offsets per addressing mode
  always_comb begin
    off_nxt        = '0;
    off_nxt.pass   = dec.pass;
    off_nxt.size   = dec.size;
    off_nxt.load   = dec.load;
    off_nxt.cnt    = dec.cnt;
    off_nxt.dword  = dec.dword;
    off_nxt.rd_bad = dec.rd_bad;
    off_nxt.rn     = dec.rn;
    case (dec.kind)
      K_SINGLE: begin
        off_nxt.a_off  = dec.p ? moved : 32'd0;
        off_nxt.nb_off = moved;
        off_nxt.e_off  = dec.p ? moved : 32'd0;
        off_nxt.wb_pre = dec.p ? dec.w : 1'b1;
      end
      K_MULTI: begin
        off_nxt.wb_pre = dec.w;
        if (dec.u) begin
          off_nxt.a_off  = dec.p ? MULTI_STEP : 32'd0;
          off_nxt.nb_off = bytes;
          off_nxt.e_off  = dec.p ? bytes : (bytes - MULTI_STEP);
        end else begin
          off_nxt.a_off  = dec.p ? nbytes : (MULTI_STEP - bytes);
          off_nxt.nb_off = nbytes;
          off_nxt.e_off  = dec.p ? (~MULTI_STEP + 32'd1) : 32'd0;
        end
      end
      default: begin
        // Undefined encoding keeps every address at the base
        off_nxt.undef = 1'b1;
        off_nxt.size  = SZ_WORD;
        off_nxt.cnt   = 5'd0;
        off_nxt.dword = 1'b0;
      end
    endcase
  end

  // Advance when the register is empty or its transaction moves on
  assign ready_in = !valid_r || ready_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      off_r <= off_nxt;
    end
  end

endmodule

// ===== rtl/core/lsag_address.sv =====
// ----------------------------------------------------------------------------
// Load/store address generator address stage
// Adds the offsets to the base, checks doubleword alignment and registers
// the finished result for the output channel.
// ----------------------------------------------------------------------------
module lsag_address
  import lsag_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic valid_in,
  output logic ready_in,
  input  off_t off,
  output logic valid_r,
  input  logic ready_out,
  output res_t res_r
);

  res_t        res_nxt;
  logic [31:0] addr;
  status_t     status;

  assign addr = off.rn + off.a_off;

  // Classify the outcome
  always_comb begin
    if (off.undef) begin
      status = ST_UNDEF;
    end else if (off.dword && (off.rd_bad || (addr[2:0] != 3'd0))) begin
      status = ST_UNPRED;
    end else begin
      status = ST_OK;
    end
  end

  // Assemble the result
  always_comb begin
    res_nxt.pass     = off.pass;
    res_nxt.addr     = addr;
    res_nxt.end_addr = off.rn + off.e_off;
    res_nxt.nb       = off.rn + off.nb_off;
    res_nxt.wb       = off.wb_pre && off.pass && (status == ST_OK);
    res_nxt.size     = off.size;
    res_nxt.load     = off.load;
    res_nxt.cnt      = off.cnt;
    res_nxt.status   = status;
  end

  // Hold the result until the output transaction completes
  assign ready_in = !valid_r || ready_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/load_store_address_generator.sv =====
// ----------------------------------------------------------------------------
// Load/store address generator
// Decodes one load/store instruction per transaction and returns its
// condition result, addresses, base update, size and transfer count.
// ----------------------------------------------------------------------------
// The block accepts one instruction per clock while in_tready is high and returns
// each result in order through three register stages (decode, offset shift,
// address add), each with its own valid bit.
// A stalled output holds only the stages that are full; empty stages keep
// taking new transactions, so in_tready falls only when all three are full
// and out_tready is low. The block keeps no state between instructions.
`include "load_store_address_generator_defines.svh"

module load_store_address_generator
  import lsag_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // instruction[31:0], base_value[63:32], offset_value[95:64],
  // nzcv_flags[99:96], zero[103:100]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // cond_passed[0], access_address[32:1], last_address[64:33],
  // new_base[96:65], base_writeback[97], access_size[100:98], is_load[101],
  // transfer_count[106:102], status[108:107], zero[111:109]
  output logic [OUT_W-1:0] out_tdata
);

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_ready;
  dec_t s1_dec;
  off_t s2_off;
  res_t s3_res;

  lsag_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_in     (in_tvalid),
    .ready_in     (in_tready),
    .instruction  (in_tdata[31:0]),
    .base_value   (in_tdata[63:32]),
    .offset_value (in_tdata[95:64]),
    .nzcv_flags   (in_tdata[99:96]),
    .valid_r      (s1_valid),
    .ready_out    (s1_ready),
    .dec_r        (s1_dec)
  );

  lsag_offset u_offset (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s1_valid),
    .ready_in  (s1_ready),
    .dec       (s1_dec),
    .valid_r   (s2_valid),
    .ready_out (s2_ready),
    .off_r     (s2_off)
  );

  lsag_address u_address (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s2_valid),
    .ready_in  (s2_ready),
    .off       (s2_off),
    .valid_r   (out_tvalid),
    .ready_out (s3_ready),
    .res_r     (s3_res)
  );

  assign s3_ready = out_tready;

  // Pack the result fields
  assign out_tdata = {3'd0, s3_res.status, s3_res.cnt, s3_res.load, s3_res.size,
                      s3_res.wb, s3_res.nb, s3_res.end_addr, s3_res.addr,
                      s3_res.pass};

  // Assertions
  `LSAG_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_tvalid && in_tready, s1_valid,
    "accepted transaction did not reach the decode stage")
  `LSAG_ASSERT_IMP(a_wb_needs_pass, clk, rst_n, out_tvalid && s3_res.wb,
    s3_res.pass && (s3_res.status == ST_OK), "writeback without pass and ok status")
  `LSAG_ASSERT_IMP(a_undef_at_base, clk, rst_n,
    out_tvalid && (s3_res.status == ST_UNDEF),
    (s3_res.cnt == 5'd0) && (s3_res.addr == s3_res.nb) && (s3_res.addr == s3_res.end_addr),
    "undefined encoding moved the base")
  `LSAG_ASSERT_IMP(a_unpred_is_dword, clk, rst_n,
    out_tvalid && (s3_res.status == ST_UNPRED),
    (s3_res.size == SZ_DWORD) && (s3_res.cnt == 5'd2),
    "unpredictable status on a non-doubleword access")
  `LSAG_ASSERT_IMP(a_single_end, clk, rst_n,
    out_tvalid && (s3_res.size != SZ_MULTI), s3_res.end_addr == s3_res.addr,
    "single transfer end address differs from access address")

endmodule

// ===== sim/load_store_address_generator_tb.sv =====
// ----------------------------------------------------------------------------
// Load/store address generator testbench
// Sends load/store instructions through the input stream and checks every
// result against an in-bench decoder of the addressing modes. Both stream
// sides idle at random. A directed set comes first, then a long random run
// that is weighted toward well-formed encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module load_store_address_generator_tb
  import lsag_pkg::*;
();

  localparam int PIPE_DEPTH   = 3;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_LIMIT = 40;
  localparam int RANDOM_ITEMS = 1025;

  // S and H bits of the halfword/doubleword encodings
  localparam logic [1:0] MISC_SWP = 2'b00;
  localparam logic [1:0] MISC_H   = 2'b01;
  localparam logic [1:0] MISC_SB  = 2'b10;
  localparam logic [1:0] MISC_SH  = 2'b11;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int    fail_count  = 0;
  int    idle_cycles = 0;
  bit    steady      = 1'b0;
  res_t  pending_accesses[$];

  load_store_address_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder of the addressing modes
  // --------------------------------------------------------------------------
  function automatic logic [31:0] scale_offset(logic [31:0] ins, logic [31:0] rm,
                                               logic carry);
    logic [4:0]  amt;
    logic [31:0] res;
    amt = ins[11:7];
    case (shift_t'(ins[6:5]))
      SH_LSL: res = rm << amt;
      // LSR #0 encodes a shift by 32
      SH_LSR: res = (amt == 0) ? 32'h0 : rm >> amt;
      SH_ASR: res = (amt == 0) ? {32{rm[31]}} : 32'($signed(rm) >>> amt);
      // ROR #0 encodes RRX
      default: res = (amt == 0) ? {carry, rm[31:1]} : (rm >> amt) | (rm << (32 - amt));
    endcase
    return res;
  endfunction

  function automatic res_t compute_access(logic [31:0] ins, logic [31:0] rn,
                                          logic [31:0] rm, logic [3:0] flags);
    res_t        r;
    logic        n, z, c, v, p, u, w, l;
    logic        pass, single, wb, load;
    logic [31:0] off, moved, bytes, addr, endaddr, nb;
    logic [1:0]  sh;
    logic [3:0]  rd;
    logic [4:0]  cnt;
    size_t       size;
    status_t     st;

    {n, z, c, v} = flags;
    p = ins[24];
    u = ins[23];
    w = ins[21];
    l = ins[20];

    case (cond_t'(ins[31:28]))
      CC_EQ: pass = z;
      CC_NE: pass = !z;
      CC_CS: pass = c;
      CC_CC: pass = !c;
      CC_MI: pass = n;
      CC_PL: pass = !n;
      CC_VS: pass = v;
      CC_VC: pass = !v;
      CC_HI: pass = c && !z;
      CC_LS: pass = !c || z;
      CC_GE: pass = (n == v);
      CC_LT: pass = (n != v);
      CC_GT: pass = !z && (n == v);
      CC_LE: pass = z || (n != v);
      CC_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase

    addr    = rn;
    endaddr = rn;
    nb      = rn;
    wb      = 1'b0;
    size    = SZ_WORD;
    load    = l;
    cnt     = 5'd0;
    st      = ST_OK;
    off     = 32'h0;
    single  = 1'b1;
    sh      = ins[6:5];

    case (class_t'(ins[27:25]))
      CLS_IMM: begin
        off  = {20'h0, ins[11:0]};
        size = ins[22] ? SZ_BYTE : SZ_WORD;
        cnt  = 5'd1;
      end
      CLS_REG: begin
        if (ins[4]) begin
          st = ST_UNDEF;
        end else begin
          off  = (ins[11:4] != 8'h0) ? scale_offset(ins, rm, c) : rm;
          size = ins[22] ? SZ_BYTE : SZ_WORD;
          cnt  = 5'd1;
        end
      end
      CLS_MISC: begin
        if (!ins[7] || !ins[4] || sh == MISC_SWP) begin
          st = ST_UNDEF;
        end else begin
          off = ins[22] ? {24'h0, ins[11:8], ins[3:0]} : rm;
          cnt = 5'd1;
          if (l) begin
            size = (sh == MISC_SB) ? SZ_BYTE : SZ_HALF;
          end else if (sh == MISC_H) begin
            size = SZ_HALF;
          end else begin
            // LDRD / STRD live in the store half of the encoding space
            size = SZ_DWORD;
            cnt  = 5'd2;
            load = (sh == MISC_SB);
          end
        end
      end
      CLS_MULTI: begin
        cnt    = 5'($countones(ins[15:0]));
        bytes  = {25'h0, cnt, 2'b00};
        single = 1'b0;
        size   = SZ_MULTI;
        if (u) begin
          addr = p ? rn + MULTI_STEP : rn;
          nb   = rn + bytes;
        end else begin
          addr = p ? rn - bytes : rn - bytes + MULTI_STEP;
          nb   = rn - bytes;
        end
        endaddr = addr + bytes - MULTI_STEP;
        wb      = w;
      end
      default: st = ST_UNDEF;
    endcase

    if (st == ST_UNDEF) begin
      addr   = rn;
      nb     = rn;
      wb     = 1'b0;
      size   = SZ_WORD;
      cnt    = 5'd0;
      load   = l;
      single = 1'b1;
    end else if (single) begin
      moved = u ? rn + off : rn - off;
      if (p) begin
        addr = moved;
        nb   = moved;
        wb   = w;
      end else begin
        // post-indexed, W is ignored and the base is always updated
        addr = rn;
        nb   = moved;
        wb   = 1'b1;
      end
      if (size == SZ_DWORD) begin
        rd = ins[15:12];
        if (rd[0] || rd == RD_LR || addr[2:0] != 3'b000)
          st = ST_UNPRED;
      end
    end
    if (single)
      endaddr = addr;
    if (st != ST_OK)
      wb = 1'b0;

    r.pass     = pass;
    r.addr     = addr;
    r.end_addr = endaddr;
    r.nb       = nb;
    r.wb       = wb & pass;
    r.size     = size;
    r.load     = load;
    r.cnt      = cnt;
    r.status   = st;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Instruction builders
  // --------------------------------------------------------------------------
  function automatic logic [31:0] word_imm(cond_t cc, logic p, logic u, logic b,
                                           logic w, logic l, logic [11:0] imm);
    return {cc, CLS_IMM, p, u, b, w, l, 8'($urandom), imm};
  endfunction

  function automatic logic [31:0] word_reg(cond_t cc, logic p, logic u, logic b,
                                           logic w, logic l, logic [4:0] amt,
                                           shift_t stype);
    return {cc, CLS_REG, p, u, b, w, l, 8'($urandom), amt, stype, 1'b0, 4'($urandom)};
  endfunction

  function automatic logic [31:0] misc_op(cond_t cc, logic p, logic u, logic i,
                                          logic w, logic l, logic [3:0] rd,
                                          logic [3:0] hi, logic [1:0] sh,
                                          logic [3:0] lo);
    return {cc, CLS_MISC, p, u, i, w, l, 4'($urandom), rd, hi, 1'b1, sh, 1'b1, lo};
  endfunction

  function automatic logic [31:0] multi_op(cond_t cc, logic p, logic u, logic s,
                                           logic w, logic l, logic [15:0] regs);
    return {cc, CLS_MULTI, p, u, s, w, l, 4'($urandom), regs};
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Mostly random words, with the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, random gap before it
  // --------------------------------------------------------------------------
  task automatic send_instr(logic [31:0] ins, logic [31:0] base, logic [31:0] ofs,
                            logic [3:0] nzcv);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {4'h0, nzcv, ofs, base, ins};
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // Output side: random stall before each result
  initial begin : result_ready
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Prediction and checking, sampled at the falling edge before the accepting edge
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(negedge clk) begin : access_check
    res_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_accesses.push_back(compute_access(in_tdata[31:0], in_tdata[63:32],
                                                  in_tdata[95:64], in_tdata[99:96]));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[108:0]);
        if (pending_accesses.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $error("result transaction with no instruction pending");
        end else begin
          want = pending_accesses.pop_front();
          compare_field("cond_passed", want.pass, got.pass);
          compare_field("access_address", want.addr, got.addr);
          compare_field("last_address", want.end_addr, got.end_addr);
          compare_field("new_base", want.nb, got.nb);
          compare_field("base_writeback", want.wb, got.wb);
          compare_field("access_size", want.size, got.size);
          compare_field("is_load", want.load, got.load);
          compare_field("transfer_count", want.cnt, got.cnt);
          compare_field("status", want.status, got.status);
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_word_byte();
    // offset add wraps past the top
    send_instr(word_imm(CC_AL, 1, 1, 0, 0, 1, 12'hFFF), 32'hFFFF_FFFF, 32'h0, 4'h0);
    // pre-indexed byte store wraps below zero
    send_instr(word_imm(CC_AL, 1, 0, 1, 1, 0, 12'h001), 32'h0, 32'hFFFF_FFFF, 4'h0);
    send_instr(word_imm(CC_AL, 0, 1, 0, 0, 1, 12'h000), 32'h8000_0000, 32'h0, 4'h0);
    // P=0 W=1 still behaves as post-indexed
    send_instr(word_imm(CC_AL, 0, 0, 1, 1, 1, 12'h800), 32'h1234_5678, 32'h0, 4'h0);
    // plain register offset
    send_instr(word_reg(CC_AL, 1, 1, 0, 1, 0, 5'd0, SH_LSL), 32'h1000, 32'hFFFF_FFFF,
               4'h0);
  endtask

  task automatic test_scaled_offsets();
    send_instr(word_reg(CC_AL, 1, 1, 0, 0, 1, 5'd31, SH_LSL), 32'h10, 32'h1, 4'h0);
    send_instr(word_reg(CC_AL, 1, 0, 0, 0, 1, 5'd0, SH_LSR), 32'h10, 32'hFFFF_FFFF,
               4'h0);
    send_instr(word_reg(CC_AL, 1, 1, 0, 0, 1, 5'd0, SH_ASR), 32'h10, 32'h8000_0000,
               4'h0);
    send_instr(word_reg(CC_AL, 1, 1, 0, 1, 1, 5'd7, SH_ASR), 32'h100, 32'hF000_0000,
               4'h0);
    // RRX pulls the carry in at the top
    send_instr(word_reg(CC_AL, 1, 1, 0, 0, 1, 5'd0, SH_ROR), 32'h0, 32'h3, 4'b0010);
    send_instr(word_reg(CC_AL, 0, 1, 1, 0, 0, 5'd31, SH_ROR), 32'h40, 32'h1, 4'h0);
  endtask

  task automatic test_misc_transfers();
    send_instr(misc_op(CC_AL, 1, 1, 1, 0, 1, 4'h0, 4'hF, MISC_H, 4'hF), 32'h100,
               32'h0, 4'h0);
    // register form ignores bits 11:8
    send_instr(misc_op(CC_AL, 1, 0, 0, 1, 1, 4'h3, 4'hA, MISC_SB, 4'h5), 32'h100,
               32'h20, 4'h0);
    send_instr(misc_op(CC_AL, 0, 1, 1, 0, 0, 4'h1, 4'h2, MISC_H, 4'h4), 32'h200,
               32'h0, 4'h0);
    send_instr(misc_op(CC_AL, 1, 1, 1, 1, 0, 4'h4, 4'h1, MISC_SB, 4'h0), 32'h1000,
               32'h0, 4'h0);
    send_instr(misc_op(CC_AL, 0, 0, 0, 0, 0, 4'h0, 4'h0, MISC_SH, 4'h0), 32'h2000,
               32'h8, 4'h0);
    // doubleword with an odd register, the link register, a misaligned address
    send_instr(misc_op(CC_AL, 1, 1, 1, 1, 0, 4'h3, 4'h0, MISC_SB, 4'h8), 32'h1000,
               32'h0, 4'h0);
    send_instr(misc_op(CC_AL, 1, 1, 1, 1, 0, 4'hE, 4'h0, MISC_SH, 4'h8), 32'h1000,
               32'h0, 4'h0);
    send_instr(misc_op(CC_AL, 1, 1, 1, 1, 0, 4'h2, 4'h0, MISC_SB, 4'h0), 32'h1004,
               32'h0, 4'h0);
  endtask

  task automatic test_multiple();
    send_instr(multi_op(CC_AL, 0, 1, 0, 1, 1, 16'h00F0), 32'h1000, 32'h0, 4'h0);
    // S bit is ignored
    send_instr(multi_op(CC_AL, 1, 0, 1, 1, 0, 16'h8001), 32'h10, 32'h0, 4'h0);
    // empty register list moves nothing
    send_instr(multi_op(CC_AL, 0, 0, 0, 1, 1, 16'h0000), 32'h0, 32'h0, 4'h0);
    send_instr(multi_op(CC_AL, 1, 1, 0, 1, 1, 16'hFFFF), 32'hFFFF_FFF0, 32'h0, 4'h0);
  endtask

  task automatic test_undefined();
    send_instr({CC_AL, CLS_REG, 5'b11001, 8'h12, 12'h013}, 32'hCAFE_0000, 32'h4, 4'h0);
    send_instr({CC_AL, CLS_MISC, 5'b11001, 8'h12, 12'h039}, 32'h1234, 32'h4, 4'h0);
    send_instr({CC_AL, CLS_MISC, 5'b11000, 8'h12, 12'h099}, 32'h1234, 32'h4, 4'h0);
    send_instr({CC_AL, CLS_DP_IMM, 25'h1AB_CDEF}, 32'h5555_5555, 32'h0, 4'h0);
    send_instr({CC_AL, CLS_SWI, 25'h0FF_FFFF}, 32'hAAAA_AAAA, 32'h0, 4'h0);
  endtask

  task automatic test_conditions();
    // never-condition blocks the post-index writeback
    send_instr(word_imm(CC_NV, 0, 1, 0, 0, 1, 12'h004), 32'h100, 32'h0, 4'hF);
    send_instr(word_imm(CC_EQ, 1, 1, 0, 1, 1, 12'h004), 32'h100, 32'h0, 4'h0);
    send_instr(word_imm(CC_GT, 1, 1, 0, 1, 1, 12'h004), 32'h100, 32'h0, 4'b1001);
  endtask

  task automatic test_random();
    logic [31:0] ins, base, ofs;
    logic [15:0] regs;
    logic [3:0]  lo;
    logic [3:0]  nzcv;
    int          pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every third stretch runs with no idling on either side
      steady = ((i / 150) % 3) == 2;
      base   = pick_word();
      ofs    = pick_word();
      nzcv   = 4'($urandom);
      pick   = $urandom_range(0, 99);
      if (pick < 22) begin
        ins = word_imm(cond_t'($urandom_range(0, 15)), rbit(), rbit(), rbit(), rbit(),
                       rbit(), 12'($urandom));
      end else if (pick < 44) begin
        ins = word_reg(cond_t'($urandom_range(0, 15)), rbit(), rbit(), rbit(), rbit(),
                       rbit(), 5'($urandom), shift_t'($urandom_range(0, 3)));
      end else if (pick < 66) begin
        lo = 4'($urandom);
        // keep doublewords aligned often enough to pass the checks
        if (rbit()) begin
          base[2:0] = 3'b000;
          ofs[2:0]  = 3'b000;
          lo[2:0]   = 3'b000;
        end
        ins = misc_op(cond_t'($urandom_range(0, 15)), rbit(), rbit(), rbit(), rbit(),
                      rbit(), 4'($urandom), 4'($urandom), 2'($urandom_range(1, 3)), lo);
      end else if (pick < 88) begin
        case ($urandom_range(0, 3))
          0:       regs = 16'($urandom);
          1:       regs = 16'h1 << $urandom_range(0, 15);
          2:       regs = 16'($urandom) & 16'($urandom);
          default: regs = rbit() ? 16'h0000 : 16'hFFFF;
        endcase
        ins = multi_op(cond_t'($urandom_range(0, 15)), rbit(), rbit(), rbit(), rbit(),
                       rbit(), regs);
      end else begin
        ins = $urandom;
      end
      send_instr(ins, base, ofs, nzcv);
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_word_byte();
    test_scaled_offsets();
    test_misc_transfers();
    test_multiple();
    test_undefined();
    test_conditions();
    test_random();

    // drain the pipeline, then give it a few more cycles
    in_tvalid <= 1'b0;
    while (pending_accesses.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
